@@ rtl/core/ssb_pkg.sv @@
// Shared types, codes and constants of the sprite sort and batch block.
package ssb_pkg;

	localparam int TEX_W          = 16;
	localparam int DEPTH_W        = 16;
	localparam int ARR_W          = 6;
	localparam int OFF_W          = 9;
	localparam int DEF_MAX_GLYPHS = 64;

	localparam logic [OFF_W-1:0] VERTS_PER_GLYPH = OFF_W'(6);

	typedef enum logic [1:0] {
		ACT_BEGIN = 2'd0,
		ACT_DRAW  = 2'd1,
		ACT_END   = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		MODE_NONE       = 2'd0,
		MODE_DEPTH_UP   = 2'd1,
		MODE_DEPTH_DOWN = 2'd2,
		MODE_TEX_UP     = 2'd3
	} mode_t;

	localparam mode_t SORT_MODE_RESET = MODE_TEX_UP;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY,
		ST_CMP,
		ST_PLACE,
		ST_ERELOAD,
		ST_EFIRST,
		ST_ENEXT,
		ST_EWAIT
	} seq_state_t;

	typedef struct packed {
		logic [TEX_W-1:0]   texture;
		logic [DEPTH_W-1:0] depth;
		logic [ARR_W-1:0]   arrival;
	} glyph_t;

	typedef struct packed {
		logic [ARR_W-1:0] glyph_index;
		logic [TEX_W-1:0] glyph_texture;
		logic [OFF_W-1:0] vertex_offset;
		logic             starts_batch;
		logic             ends_batch;
		logic [OFF_W-1:0] batch_offset;
		logic [OFF_W-1:0] batch_vertices;
		logic             dropped;
		logic             last;
	} result_t;

endpackage

@@ rtl/core/sprite_sort_and_batch.sv @@
// Top level of the sprite sort and batch block: mode register, glyph store, sequencer.
//
// Collects sprite glyphs between a begin beat and an end beat, then replays them
// stably ordered by sort_mode (arrival, ascending depth, descending depth or
// ascending texture), one result beat per glyph, with texture batch marks and
// vertex offsets at six vertices per glyph. An end beat over n stored glyphs
// first runs an insertion sort through the single shared compare unit and the
// one-read, one-write glyph RAM: a key read and a final compare or placement for
// each glyph after the first, one more compare for each glyph moved past another
// (n*(n-1)/2 moves at worst), and a reload step when the last glyph sorted lands
// in slot zero; the sort is skipped entirely in arrival mode or with fewer than
// two glyphs. Emission then primes the first glyph and sends each result through
// a load step and a wait for its take, held while the output is stalled. The block
// stalls its input from the end beat until the last result beat is taken. The glyph
// RAM needs no clearing pass after reset. Draws beyond MAX_GLYPHS are dropped and
// reported on every result until the next begin.
module sprite_sort_and_batch
	import ssb_pkg::*;
#(
	parameter int MAX_GLYPHS = DEF_MAX_GLYPHS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                action,
	input  logic [TEX_W-1:0]          texture_id,
	input  logic signed [DEPTH_W-1:0] depth_key,
	// result channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [ARR_W-1:0]          glyph_index,
	output logic [TEX_W-1:0]          glyph_texture,
	output logic [OFF_W-1:0]          vertex_offset,
	output logic                      starts_batch,
	output logic                      ends_batch,
	output logic [OFF_W-1:0]          batch_offset,
	output logic [OFF_W-1:0]          batch_vertices,
	output logic                      dropped,
	output logic                      last,
	// sort mode register
	input  logic                      cfg_write_en,
	input  logic [1:0]                cfg_write_data
);

	localparam int AW = $clog2(MAX_GLYPHS);

	mode_t         sort_mode_q;
	result_t       res;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	glyph_t        ram_wdata;
	logic [AW-1:0] ram_raddr;
	glyph_t        ram_rdata;

	// the sequencer reads the mode throughout an end run; write it only while idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_mode_q <= SORT_MODE_RESET;
		end else if (cfg_write_en) begin
			sort_mode_q <= mode_t'(cfg_write_data);
		end
	end

	// glyph store: texture, depth and arrival index packed in one word
	ssb_ram #(
		.WIDTH  ($bits(glyph_t)),
		.DEPTH  (MAX_GLYPHS),
		.ADDR_W (AW)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ssb_seq #(
		.MAX_GLYPHS (MAX_GLYPHS),
		.AW         (AW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.texture_id (texture_id),
		.depth_key  (depth_key),
		.sort_mode  (sort_mode_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.res        (res),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	assign glyph_index    = res.glyph_index;
	assign glyph_texture  = res.glyph_texture;
	assign vertex_offset  = res.vertex_offset;
	assign starts_batch   = res.starts_batch;
	assign ends_batch     = res.ends_batch;
	assign batch_offset   = res.batch_offset;
	assign batch_vertices = res.batch_vertices;
	assign dropped        = res.dropped;
	assign last           = res.last;

	// a pending result always holds off new input
	a_busy_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while a result is pending");

	// taking the final result frees the input on the next cycle
	a_free_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last) |=> !in_stall)
		else $error("input still stalled after the final result");

	// a batch opens at this glyph's own slot with one glyph's vertices
	a_batch_open: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && starts_batch) |->
			(batch_offset == vertex_offset && batch_vertices == VERTS_PER_GLYPH))
		else $error("batch start marks inconsistent");

	// the final glyph always closes its batch
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> ends_batch)
		else $error("final result does not close its batch");

endmodule

@@ rtl/core/ssb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ssb_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/ssb_order_cmp.sv @@
// Shared order compare unit: true when glyph a must go strictly before glyph b.
module ssb_order_cmp
	import ssb_pkg::*;
(
	input  mode_t  mode,
	input  glyph_t a,
	input  glyph_t b,
	output logic   a_first
);

	always_comb begin
		unique case (mode)
			MODE_DEPTH_UP:   a_first = $signed(a.depth) < $signed(b.depth);
			MODE_DEPTH_DOWN: a_first = $signed(b.depth) < $signed(a.depth);
			MODE_TEX_UP:     a_first = a.texture < b.texture;
			MODE_NONE:       a_first = 1'b0;
			default:         a_first = 1'b0;
		endcase
	end

endmodule

@@ rtl/core/ssb_seq.sv @@
// Sequencer: glyph store writes, insertion sort over the RAM, batch emission.
module ssb_seq
	import ssb_pkg::*;
#(
	parameter int MAX_GLYPHS = DEF_MAX_GLYPHS,
	parameter int CW         = $clog2(MAX_GLYPHS + 1),
	parameter int AW         = $clog2(MAX_GLYPHS)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                action,
	input  logic [TEX_W-1:0]          texture_id,
	input  logic signed [DEPTH_W-1:0] depth_key,
	input  mode_t                     sort_mode,
	output logic                      out_valid,
	input  logic                      out_stall,
	output result_t                   res,
	output logic                      ram_we,
	output logic [AW-1:0]             ram_waddr,
	output glyph_t                    ram_wdata,
	output logic [AW-1:0]             ram_raddr,
	input  glyph_t                    ram_rdata
);

	seq_state_t       state_q, state_d;
	logic [CW-1:0]    count_q;
	logic             ovf_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    j_q;
	glyph_t           key_q;
	glyph_t           cur_q;
	logic [TEX_W-1:0] prev_tex_q;
	logic [OFF_W-1:0] voff_q;
	logic [OFF_W-1:0] bstart_q;
	logic [OFF_W-1:0] bverts_q;
	logic             out_valid_q;
	result_t          res_q;

	logic          in_acc;
	logic          out_take;
	logic          count_full;
	logic          do_sort;
	logic          sort_done;
	logic [CW-1:0] idx_inc;
	logic [CW:0]   idx_p2;
	logic [CW-1:0] waddr_c;
	logic [CW-1:0] raddr_c;
	logic          a_first;
	result_t       res_c;

	ssb_order_cmp u_cmp (
		.mode    (sort_mode),
		.a       (key_q),
		.b       (ram_rdata),
		.a_first (a_first)
	);

	assign in_stall   = (state_q != ST_IDLE);
	assign in_acc     = in_valid && (state_q == ST_IDLE);
	assign out_take   = out_valid_q && !out_stall;
	assign count_full = (count_q == CW'(MAX_GLYPHS));
	assign do_sort    = (sort_mode != MODE_NONE) && (count_q > CW'(1));
	assign idx_inc    = idx_q + CW'(1);
	assign idx_p2     = {1'b0, idx_q} + (CW+1)'(2);
	assign sort_done  = (idx_inc == count_q);

	// next state and RAM port
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		waddr_c   = '0;
		ram_wdata = key_q;
		raddr_c   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (action)
						ACT_DRAW: begin
							if (!count_full) begin
								ram_we    = 1'b1;
								waddr_c   = count_q;
								ram_wdata = '{texture: texture_id,
								              depth:   depth_key,
								              arrival: ARR_W'(count_q)};
							end
						end
						ACT_END: begin
							if (count_q != '0) begin
								if (do_sort) begin
									raddr_c = CW'(1);
									state_d = ST_KEY;
								end else begin
									state_d = ST_EFIRST;
								end
							end
						end
						default: ;
					endcase
				end
			end
			ST_KEY: begin
				raddr_c = idx_q - CW'(1);
				state_d = ST_CMP;
			end
			ST_CMP: begin
				ram_we  = 1'b1;
				waddr_c = j_q;
				if (a_first) begin
					// shift the neighbor up one slot
					ram_wdata = ram_rdata;
					if (j_q == CW'(1)) begin
						state_d = ST_PLACE;
					end else begin
						raddr_c = j_q - CW'(2);
					end
				end else begin
					ram_wdata = key_q;
					if (sort_done) begin
						state_d = ST_EFIRST;
					end else begin
						raddr_c = idx_inc;
						state_d = ST_KEY;
					end
				end
			end
			ST_PLACE: begin
				ram_we    = 1'b1;
				ram_wdata = key_q;
				if (sort_done) begin
					// slot zero is written at this edge; read it back next cycle
					state_d = ST_ERELOAD;
				end else begin
					raddr_c = idx_inc;
					state_d = ST_KEY;
				end
			end
			ST_ERELOAD: begin
				state_d = ST_EFIRST;
			end
			ST_EFIRST: begin
				if (count_q > CW'(1)) begin
					raddr_c = CW'(1);
				end
				state_d = ST_ENEXT;
			end
			ST_ENEXT: begin
				state_d = ST_EWAIT;
			end
			ST_EWAIT: begin
				if (out_take) begin
					if (res_q.last) begin
						state_d = ST_IDLE;
					end else begin
						if (idx_p2 < {1'b0, count_q}) begin
							raddr_c = idx_p2[CW-1:0];
						end
						state_d = ST_ENEXT;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign ram_waddr = waddr_c[AW-1:0];
	assign ram_raddr = raddr_c[AW-1:0];

	// result of the glyph held in cur_q; ram_rdata holds its successor
	always_comb begin
		res_c.glyph_index   = cur_q.arrival;
		res_c.glyph_texture = cur_q.texture;
		res_c.vertex_offset = voff_q;
		res_c.starts_batch  = (idx_q == '0) || (cur_q.texture != prev_tex_q);
		res_c.last          = sort_done;
		res_c.ends_batch    = sort_done || (cur_q.texture != ram_rdata.texture);
		res_c.batch_offset  = res_c.starts_batch ? voff_q : bstart_q;
		res_c.batch_vertices = res_c.starts_batch ? VERTS_PER_GLYPH
		                                          : bverts_q + VERTS_PER_GLYPH;
		res_c.dropped       = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				unique case (action)
					ACT_BEGIN: begin
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
					ACT_DRAW: begin
						if (count_full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
					end
					default: ;
				endcase
			end
			if (state_q == ST_ENEXT) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && action == ACT_END) begin
					idx_q <= do_sort ? CW'(1) : '0;
				end
			end
			ST_KEY: begin
				key_q <= ram_rdata;
				j_q   <= idx_q;
			end
			ST_CMP: begin
				if (a_first) begin
					j_q <= j_q - CW'(1);
				end else begin
					idx_q <= sort_done ? '0 : idx_inc;
				end
			end
			ST_PLACE: begin
				idx_q <= sort_done ? '0 : idx_inc;
			end
			ST_EFIRST: begin
				cur_q  <= ram_rdata;
				voff_q <= '0;
			end
			ST_ENEXT: begin
				res_q      <= res_c;
				cur_q      <= ram_rdata;
				prev_tex_q <= cur_q.texture;
				voff_q     <= voff_q + VERTS_PER_GLYPH;
				bstart_q   <= res_c.batch_offset;
				bverts_q   <= res_c.batch_vertices;
			end
			ST_EWAIT: begin
				if (out_take && !res_q.last) begin
					idx_q <= idx_inc;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule
